// ----- rtl/core/mnst_pkg.sv -----
// shared types and constants for the midi note span tracker
// no dependencies; used by the top level and the checker
package mnst_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int OUT_TIME_BITS = 48;
  localparam int KEY_BITS      = 7;
  localparam int DATA_BITS     = 7;
  localparam int CHAN_BITS     = 4;
  localparam int DELTA_BITS    = 28;
  localparam int NOTE_COUNT    = 128;

  typedef enum logic [1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_PROGRAM  = 2'd2,
    CMD_OTHER    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [DELTA_BITS-1:0] delta_time;
    logic [CHAN_BITS-1:0]  event_channel;
    logic [KEY_BITS-1:0]   note_key;
    logic [DATA_BITS-1:0]  data_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_TIME_BITS-1:0] out_start;
    logic [OUT_TIME_BITS-1:0] out_duration;
    logic [DATA_BITS-1:0]     out_velocity;
    logic [KEY_BITS-1:0]      out_key;
    logic [DATA_BITS-1:0]     out_program;
  } out_item_t;

endpackage

// ----- rtl/core/mnst_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module mnst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/midi_note_span_tracker.sv -----
// midi note span tracker: pairs note on / note off of one channel into note spans
// depends on mnst_pkg and mnst_ram (note table)
// result path: the event's note table read is registered, then the finished note is registered into the output register
// events: a new event is taken only once the last one is done (read then modify-write of one note table
//   entry in the ram); the write cycle waits while a finished note is still held and this event ends another
// reset: synchronous, active low; active bits cleared at once, no clearing pass
module midi_note_span_tracker #(
  parameter int TIME_BITS = mnst_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mnst_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mnst_pkg::out_item_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [mnst_pkg::CHAN_BITS-1:0]   cfg_wr_data
);

  localparam int KEY_W   = mnst_pkg::KEY_BITS;
  localparam int DATA_W  = mnst_pkg::DATA_BITS;
  localparam int ENTRY_W = TIME_BITS + 2 * DATA_W;

  typedef enum logic {
    S_IDLE,
    S_RMW
  } state_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] start;
    logic [DATA_W-1:0]    velocity;
    logic [DATA_W-1:0]    prog;
  } entry_t;

  state_t                         state_r;
  logic [TIME_BITS-1:0]           time_r;
  logic [DATA_W-1:0]              prog_r;
  logic [mnst_pkg::CHAN_BITS-1:0] own_channel_r;
  logic [mnst_pkg::NOTE_COUNT-1:0] note_active_r;
  logic                           is_note_r;
  logic                           note_start_r;
  logic [KEY_W-1:0]               key_r;
  logic [DATA_W-1:0]              velocity_r;
  logic                           out_valid_r;
  mnst_pkg::out_item_t            out_data_r;

  logic                 in_xfer;
  logic                 own_event;
  logic [TIME_BITS-1:0] time_nxt;
  logic                 hit;
  logic                 proceed;
  logic                 emit;
  logic                 wr_en;
  entry_t               wr_entry;
  entry_t               rd_entry;
  logic [ENTRY_W-1:0]   rd_raw;
  logic [TIME_BITS-1:0] duration;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign own_event = (in_data.event_channel == own_channel_r);
  assign time_nxt  = time_r + TIME_BITS'(in_data.delta_time);

  assign rd_entry = entry_t'(rd_raw);
  assign hit      = is_note_r && note_active_r[key_r];
  // hold the write cycle while the output register still has an untaken note and this event ends another
  assign proceed  = !hit || !out_valid_r || out_ready;
  assign emit     = (state_r == S_RMW) && proceed && hit;
  assign duration = time_r - rd_entry.start;

  assign wr_en             = (state_r == S_RMW) && proceed && note_start_r;
  assign wr_entry.start    = time_r;
  assign wr_entry.velocity = velocity_r;
  assign wr_entry.prog     = prog_r;

  mnst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (mnst_pkg::NOTE_COUNT)
  ) u_note_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (key_r),
    .wr_data (ENTRY_W'(wr_entry)),
    .rd_en   (in_xfer),
    .rd_addr (in_data.note_key),
    .rd_data (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      time_r        <= '0;
      prog_r        <= '0;
      own_channel_r <= '0;
      note_active_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        own_channel_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            time_r       <= time_nxt;
            key_r        <= in_data.note_key;
            velocity_r   <= in_data.data_value;
            is_note_r    <= own_event && (in_data.cmd inside {mnst_pkg::CMD_NOTE_ON,
                                                               mnst_pkg::CMD_NOTE_OFF});
            note_start_r <= own_event && (in_data.cmd == mnst_pkg::CMD_NOTE_ON) &&
                            (in_data.data_value != '0);
            if (own_event && (in_data.cmd == mnst_pkg::CMD_PROGRAM)) begin
              prog_r <= in_data.data_value;
            end
            state_r <= S_RMW;
          end
        end
        S_RMW: begin
          if (proceed) begin
            if (hit) begin
              out_data_r.out_start    <= mnst_pkg::OUT_TIME_BITS'(64'(rd_entry.start));
              out_data_r.out_duration <= mnst_pkg::OUT_TIME_BITS'(64'(duration));
              out_data_r.out_velocity <= rd_entry.velocity;
              out_data_r.out_key      <= key_r;
              out_data_r.out_program  <= rd_entry.prog;
            end
            // retrigger and plain note on with nonzero velocity both leave the note sounding
            if (is_note_r) begin
              note_active_r[key_r] <= note_start_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/mnst_checker.sv -----
// port-level checks for the midi note span tracker, bound to the top level
// depends on mnst_pkg
module mnst_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mnst_pkg::out_item_t out_data
);

  // a held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // one event in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("event accepted while previous still in work");

  // a fresh result must follow an event transfer
  a_result_follows_event: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding event");

  // only notes struck with nonzero velocity are ever reported
  a_velocity_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_velocity != '0)
    else $error("reported note has zero velocity");

endmodule

bind midi_note_span_tracker mnst_checker u_mnst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
